// ----- src/escape_sequence_decoder_top_assert.svh -----
// Assertion macros for the escape sequence decoder.
`ifndef ESCAPE_SEQUENCE_DECODER_TOP_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk and ignored while arst_n is low.
`define ESD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and ignored while arst_n is low.
`define ESD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/esd_pkg.sv -----
// Types, constants and helper functions of the escape sequence decoder.
`timescale 1ns / 1ps

package esd_pkg;

	localparam int KEY_CHAR_BITS_DEF    = 7;
	localparam int MAX_BRACE_DIGITS_DEF = 8;

	localparam int CP_W     = 21;
	localparam int ESC_W    = 7;
	localparam int KEYF_W   = 7;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 8;

	localparam logic [ESC_W-1:0] ESC_RESET = 7'd92;

	localparam logic [7:0] CH_LOWER_U = 8'h75;
	localparam logic [7:0] CH_UPPER_U = 8'h55;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// held bytes (escape, prefix, digits) that complete a fixed-length code
	localparam int BMP_HELD = 6;
	localparam int UCS_HELD = 8;

	typedef struct packed {
		logic            valid;
		logic [CP_W-1:0] cp;
	} entry_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [2:0]      n;
		logic [3:0][7:0] b;
	} utf_t;

	function automatic logic is_key_char(input logic [7:0] c);
		logic r;
		r = (c == 8'h21) || (c == 8'h22)
			|| (c >= 8'h25 && c <= 8'h3F)  // punctuation and digits
			|| (c >= 8'h41 && c <= 8'h5A)
			|| (c == 8'h5E) || (c == 8'h5F)
			|| (c >= 8'h61 && c <= 8'h7A);
		return r;
	endfunction

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.val = c[3:0];
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r.val = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic logic bad_code(input logic [31:0] cp);
		return (cp > 32'h0010_FFFF) || (cp >= 32'h0000_D800 && cp <= 32'h0000_DFFF);
	endfunction

	function automatic utf_t utf8_encode(input logic [CP_W-1:0] cp);
		utf_t r;
		r.b = '0;
		if (cp < 21'h80) begin
			r.n    = 3'd1;
			r.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			r.n    = 3'd2;
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.n    = 3'd3;
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
		end else begin
			r.n    = 3'd4;
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

// ----- src/escape_sequence_decoder_top.sv -----
// Escape sequence decoder: byte stream with escapes in, UTF-8 bytes out.
//
//  channel   | dir | carries
//  ----------+-----+-------------------------------------------------------
//  s_*       | in  | tuser action; tdata byte, digraph key, code point
//  m_*       | out | tdata one output byte; tlast on the request's last byte
//  cfg_*     | in  | escape byte register, write only
//
// A data request waits in the parse stage until the output side can take its bytes;
// the digraph table is read on both ports in the accept cycle. With results drained,
// one request enters per cycle; a request with n output bytes holds the output side
// until its last byte is taken. After reset a clearing pass writes all of the
// 2**(2*KEY_CHAR_BITS) table entries (16384 at default), one per cycle, with s_tready low.
`timescale 1ns / 1ps
`include "escape_sequence_decoder_top_assert.svh"

module escape_sequence_decoder_top #(
	parameter int KEY_CHAR_BITS    = esd_pkg::KEY_CHAR_BITS_DEF,
	parameter int MAX_BRACE_DIGITS = esd_pkg::MAX_BRACE_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// data_byte[7:0], key_first[14:8], key_second[21:15], code_point[42:22], zero fill
	input  logic [esd_pkg::S_DATA_W-1:0] s_tdata,
	// action[0]
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// out_byte[7:0]
	output logic [esd_pkg::M_DATA_W-1:0] m_tdata,
	output logic                         m_tlast,
	input  logic                         cfg_we,
	input  logic [esd_pkg::ESC_W-1:0]    cfg_wdata
);
	import esd_pkg::*;

	localparam int KEY_W      = KEY_CHAR_BITS;
	localparam int TBL_AW     = 2 * KEY_W;
	localparam int TBL_DEPTH  = 1 << TBL_AW;
	localparam int PEND_DEPTH = 2 + MAX_BRACE_DIGITS;
	localparam int PI_W       = $clog2(PEND_DEPTH);
	localparam int CNT_W      = $clog2(PEND_DEPTH + 1);
	localparam int LEN_W      = $clog2(PEND_DEPTH + 6);
	localparam int ACC_W      = 4 * MAX_BRACE_DIGITS;

	typedef enum logic [2:0] {
		M_OUTSIDE,
		M_ESCAPE,
		M_BMP,
		M_UCS,
		M_UNI,
		M_DGR0,
		M_DGR
	} mode_t;

	// request fields
	logic [7:0]        in_byte;
	logic [KEYF_W-1:0] in_key1;
	logic [KEYF_W-1:0] in_key2;
	logic [CP_W-1:0]   in_cp;
	logic              s_accept;

	assign in_byte  = s_tdata[7:0];
	assign in_key1  = s_tdata[14:8];
	assign in_key2  = s_tdata[21:15];
	assign in_cp    = s_tdata[42:22];
	assign s_accept = s_tvalid && s_tready;

	// configuration
	logic [ESC_W-1:0] esc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= ESC_RESET;
		end else if (cfg_we && (cfg_wdata != '0)) begin
			esc_q <= cfg_wdata;
		end
	end

	// digraph table and clearing pass
	entry_t            tbl_mem [TBL_DEPTH];
	entry_t            rd1_q;
	entry_t            rd2_q;
	logic [KEY_W-1:0]  last_q;
	logic              clr_q;
	logic [TBL_AW-1:0] caddr_q;
	logic              def_wr;
	logic              mem_we;
	logic [TBL_AW-1:0] mem_waddr;
	entry_t            mem_wdata;
	logic [KEY_W-1:0]  wkey1;
	logic [KEY_W-1:0]  wkey2;
	logic              rd_en;

	always_comb begin
		wkey1 = KEY_W'(in_key1);
		wkey2 = (in_key2 == CH_SPACE[KEYF_W-1:0]) ? '0 : KEY_W'(in_key2);
		def_wr = s_accept && s_tuser && !bad_code(32'(in_cp));
		mem_we = clr_q || def_wr;
		if (clr_q) begin
			mem_waddr = caddr_q;
			mem_wdata = '0;
		end else begin
			mem_waddr       = {wkey1, wkey2};
			mem_wdata.valid = 1'b1;
			mem_wdata.cp    = in_cp;
		end
		rd_en = s_accept && !s_tuser;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= 1'b1;
			caddr_q <= '0;
		end else if (clr_q) begin
			caddr_q <= caddr_q + 1'b1;
			if (caddr_q == {TBL_AW{1'b1}}) begin
				clr_q <= 1'b0;
			end
		end
	end

	// first key of a digraph is always the data byte just before the lookup
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd1_q  <= tbl_mem[{last_q, {KEY_W{1'b0}}}];
			rd2_q  <= tbl_mem[{last_q, in_byte[KEY_W-1:0]}];
			last_q <= in_byte[KEY_W-1:0];
		end
	end

	// parse stage
	logic              s1_v_q;
	logic [7:0]        s1_b_q;
	mode_t             mode_q;
	logic [CNT_W-1:0]  pcnt_q;
	logic [ACC_W-1:0]  acc_q;
	logic [7:0]        pend_q [PEND_DEPTH];

	mode_t             nx_mode;
	logic [CNT_W-1:0]  nx_cnt;
	logic [ACC_W-1:0]  nx_acc;
	logic [ACC_W-1:0]  acc_sh;
	logic [CNT_W-1:0]  pcnt_inc;
	logic [CNT_W-1:0]  cnt_after;
	hex_t              hx;
	logic              key_ok;
	logic              is_esc;
	logic              push;
	logic              push_ok;
	logic              fin;
	logic              emit_pend;
	logic              use_utf;
	logic              tail;
	logic [CP_W-1:0]   utf_cp;
	utf_t              utf;
	logic [CNT_W-1:0]  job_pn;
	logic [2:0]        job_un;
	logic [LEN_W-1:0]  job_len;
	logic              has_out;
	logic [7:0]        pend_job [PEND_DEPTH];
	logic              s1_adv;
	logic              job_free;

	always_comb begin
		hx        = hex_decode(s1_b_q);
		key_ok    = is_key_char(s1_b_q);
		is_esc    = (s1_b_q == {1'b0, esc_q});
		acc_sh    = {acc_q[ACC_W-5:0], hx.val};
		pcnt_inc  = pcnt_q + 1'b1;
		nx_mode   = mode_q;
		nx_acc    = acc_q;
		push      = 1'b0;
		fin       = 1'b0;
		emit_pend = 1'b0;
		use_utf   = 1'b0;
		tail      = 1'b0;
		utf_cp    = '0;
		unique case (mode_q)
			M_OUTSIDE: begin
				if (is_esc) begin
					push    = 1'b1;
					nx_mode = M_ESCAPE;
				end else begin
					tail = 1'b1;
				end
			end
			M_ESCAPE: begin
				if (s1_b_q == CH_LOWER_U || s1_b_q == CH_UPPER_U
						|| s1_b_q == CH_LBRACE || s1_b_q == CH_CARET) begin
					push   = 1'b1;
					nx_acc = '0;
					priority if (s1_b_q == CH_LOWER_U) nx_mode = M_BMP;
					else if (s1_b_q == CH_UPPER_U) nx_mode = M_UCS;
					else if (s1_b_q == CH_LBRACE) nx_mode = M_UNI;
					else nx_mode = M_DGR0;
				end else if (is_esc) begin
					tail = 1'b1;
					fin  = 1'b1;
				end else if (key_ok || s1_b_q == CH_SPACE) begin
					push    = 1'b1;
					nx_mode = M_DGR;
				end else begin
					emit_pend = 1'b1;
					tail      = 1'b1;
					fin       = 1'b1;
				end
			end
			M_BMP, M_UCS: begin
				if (!hx.ok) begin
					emit_pend = 1'b1;
					tail      = 1'b1;
					fin       = 1'b1;
				end else begin
					push   = 1'b1;
					nx_acc = acc_sh;
					if (pcnt_inc >= CNT_W'((mode_q == M_BMP) ? BMP_HELD : UCS_HELD)) begin
						fin = 1'b1;
						if (bad_code(32'(acc_sh))) begin
							emit_pend = 1'b1;
						end else begin
							use_utf = 1'b1;
							utf_cp  = acc_sh[CP_W-1:0];
						end
					end
				end
			end
			M_UNI: begin
				if (hx.ok && pcnt_q < CNT_W'(PEND_DEPTH)) begin
					push   = 1'b1;
					nx_acc = acc_sh;
				end else if (!hx.ok && s1_b_q == CH_RBRACE && pcnt_q > CNT_W'(2)) begin
					fin = 1'b1;
					if (bad_code(32'(acc_q))) begin
						emit_pend = 1'b1;
						tail      = 1'b1;
					end else begin
						use_utf = 1'b1;
						utf_cp  = acc_q[CP_W-1:0];
					end
				end else begin
					emit_pend = 1'b1;
					tail      = 1'b1;
					fin       = 1'b1;
				end
			end
			M_DGR0: begin
				if (key_ok || s1_b_q == CH_SPACE) begin
					push    = 1'b1;
					nx_mode = M_DGR;
				end else begin
					emit_pend = 1'b1;
					tail      = 1'b1;
					fin       = 1'b1;
				end
			end
			M_DGR: begin
				fin = 1'b1;
				if (key_ok && rd2_q.valid) begin
					use_utf = 1'b1;
					utf_cp  = rd2_q.cp;
				end else if (rd1_q.valid) begin
					use_utf = 1'b1;
					utf_cp  = rd1_q.cp;
					tail    = 1'b1;
				end else begin
					emit_pend = 1'b1;
					tail      = 1'b1;
				end
			end
			default: begin
				emit_pend = 1'b1;
				tail      = 1'b1;
				fin       = 1'b1;
			end
		endcase

		push_ok   = push && (pcnt_q < CNT_W'(PEND_DEPTH));
		cnt_after = push_ok ? pcnt_inc : pcnt_q;
		if (fin) begin
			nx_mode = M_OUTSIDE;
			nx_cnt  = '0;
			nx_acc  = '0;
		end else begin
			nx_cnt = cnt_after;
		end

		utf     = utf8_encode(utf_cp);
		job_pn  = emit_pend ? cnt_after : '0;
		job_un  = use_utf ? utf.n : 3'd0;
		job_len = LEN_W'(job_pn) + LEN_W'(job_un) + LEN_W'(tail);
		has_out = (job_len != '0);

		for (int i = 0; i < PEND_DEPTH; i++) begin
			pend_job[i] = (push_ok && pcnt_q == CNT_W'(i)) ? s1_b_q : pend_q[i];
		end
	end

	// output job
	logic             jv_q;
	logic [LEN_W-1:0] idx_q;
	logic [LEN_W-1:0] jlen_q;
	logic [CNT_W-1:0] jpn_q;
	logic [2:0]       jun_q;
	logic [3:0][7:0]  jutf_q;
	logic [7:0]       jtb_q;
	logic [7:0]       jpend_q [PEND_DEPTH];
	logic [LEN_W-1:0] off;
	logic             out_fire;
	logic             out_done;

	assign out_fire = m_tvalid && m_tready;
	assign out_done = out_fire && m_tlast;
	assign job_free = !jv_q || out_done;
	assign s1_adv   = s1_v_q && (!has_out || job_free);
	assign s_tready = !clr_q && (!s1_v_q || s1_adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			mode_q <= M_OUTSIDE;
			pcnt_q <= '0;
			acc_q  <= '0;
		end else begin
			if (s_tready) begin
				s1_v_q <= s_tvalid && !s_tuser;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				mode_q <= nx_mode;
				pcnt_q <= nx_cnt;
				acc_q  <= nx_acc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			s1_b_q <= in_byte;
		end
		if (s1_adv && push_ok) begin
			pend_q[pcnt_q[PI_W-1:0]] <= s1_b_q;
		end
		if (s1_adv && has_out) begin
			jpend_q <= pend_job;
			jpn_q   <= job_pn;
			jun_q   <= job_un;
			jutf_q  <= utf.b;
			jtb_q   <= s1_b_q;
			jlen_q  <= job_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jv_q  <= 1'b0;
			idx_q <= '0;
		end else if (s1_adv && has_out) begin
			jv_q  <= 1'b1;
			idx_q <= '0;
		end else if (out_fire) begin
			if (m_tlast) begin
				jv_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// held bytes first, then the UTF-8 bytes, then the breaking byte
	always_comb begin
		off = idx_q - LEN_W'(jpn_q);
		if (idx_q < LEN_W'(jpn_q)) begin
			m_tdata = jpend_q[idx_q[PI_W-1:0]];
		end else if (off < LEN_W'(jun_q)) begin
			m_tdata = jutf_q[off[1:0]];
		end else begin
			m_tdata = jtb_q;
		end
	end

	assign m_tvalid = jv_q;
	assign m_tlast  = jv_q && (idx_q == jlen_q - 1'b1);

	`ESD_ASSERT_IMP(a_no_request_in_clear, clr_q, !s_tready, "request accepted during table clear")
	`ESD_ASSERT_IMP(a_idx_in_job, jv_q, idx_q < jlen_q, "output index past job length")
	`ESD_ASSERT_IMP(a_outside_empty, mode_q == M_OUTSIDE, pcnt_q == '0, "held bytes outside a sequence")
	`ESD_ASSERT_IMP(a_pend_bound, 1'b1, pcnt_q <= CNT_W'(PEND_DEPTH), "held byte count overflow")
	`ESD_ASSERT_NXT(a_job_loaded, s1_adv && has_out, jv_q && idx_q == '0, "parsed job not loaded")

endmodule
